### hw/rtl/mtmc_pkg.sv
`timescale 1ns / 1ps

package mtmc_pkg;

    // Widths of the item fields and configuration registers.
    localparam int TS_W    = 64;
    localparam int DUR_W   = 32;
    localparam int SN_W    = 3;
    localparam int CIDX_W  = 2;

    // Register values after reset.
    localparam logic [TS_W-1:0]  OFFSET_RST      = '0;
    localparam logic [DUR_W-1:0] MAX_FRAME_RST   = 32'd5000000;
    localparam logic [DUR_W-1:0] DFLT_FRAME_RST  = 32'd33333;

    // Item operation codes.
    typedef enum logic
    {
        OP_PROCESS = 1'b0,
        OP_CLEAR   = 1'b1
    } op_t;

    // Configuration register indexes.
    typedef enum logic [CIDX_W-1:0]
    {
        CFG_OFFSET     = 2'd0,
        CFG_MAX_FRAME  = 2'd1,
        CFG_DFLT_FRAME = 2'd2
    } cfg_idx_t;

endpackage

### hw/rtl/media_timestamp_monotonic_corrector_unit.sv
`timescale 1ns / 1ps

// Monotonic timestamp corrector. Each item carries a packet timestamp and a
// stream number; process items return one corrected timestamp (relative to a
// shared base time, plus offset_us), clear items return nothing and drop all
// timing history. The block takes one item every cycle while the output is
// not stalled: the accepting edge reads the stream's last stamp from a small
// synchronous memory into stage 1, stage 1 does the compare and repair and
// updates the base time and the memory (this loop is what sets the rate) and
// registers the result in stage 2, and the output register adds the offset.
// A write to the same stream by the item just ahead is forwarded, so
// back-to-back items on one stream are exact. Registers may be written only
// while no item is in flight.
module media_timestamp_monotonic_corrector_unit #(
    parameter int NUM_STREAMS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input item channel.
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              opcode,
    input  logic signed [mtmc_pkg::TS_W-1:0]  timestamp_us,
    input  logic [mtmc_pkg::SN_W-1:0]         stream_number,
    input  logic                              equal_allowed,
    input  logic                              force_discontinuity,
    // Result item channel.
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [mtmc_pkg::TS_W-1:0]  corrected_us,
    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mtmc_pkg::CIDX_W-1:0]       cfg_index,
    input  logic [mtmc_pkg::TS_W-1:0]         cfg_data
);

    localparam int AW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
    localparam int IW = (AW > mtmc_pkg::SN_W) ? AW : mtmc_pkg::SN_W;
    localparam logic [7:0] NS8 = 8'(NUM_STREAMS);
    localparam int TW = mtmc_pkg::TS_W;

    // Configuration registers.
    logic [TW-1:0]                  offset_reg;
    logic [mtmc_pkg::DUR_W-1:0]     max_frame_reg;
    logic [mtmc_pkg::DUR_W-1:0]     dflt_frame_reg;

    // Stage 1: item fields plus the memory read data.
    logic                  s1_valid_reg;
    mtmc_pkg::op_t         s1_op_reg;
    logic [TW-1:0]         s1_ts_reg;
    logic [AW-1:0]         s1_addr_reg;
    logic                  s1_inrange_reg;
    logic                  s1_primary_reg;
    logic                  s1_eq_reg;
    logic                  s1_force_reg;
    logic [TW-1:0]         rd_data_reg;

    // Stage 2 and output register.
    logic                  s2_valid_reg;
    logic [TW-1:0]         rel_reg;
    logic                  out_valid_reg;
    logic [TW-1:0]         corrected_reg;

    // Timing state.
    logic [TW-1:0]             base_reg;
    logic [TW-1:0]             base_next;
    logic                      base_known_reg;
    logic                      base_known_next;
    logic [NUM_STREAMS-1:0]    known_reg;
    logic [NUM_STREAMS-1:0]    known_next;
    logic [TW-1:0]             stamp_mem [NUM_STREAMS];

    // Last write into the stamp memory, for forwarding.
    logic                  fwd_valid_reg;
    logic [AW-1:0]         fwd_addr_reg;
    logic [TW-1:0]         fwd_data_reg;

    logic                  in_accept;
    logic [IW-1:0]         sn_ext;
    logic [AW-1:0]         in_addr;
    logic                  in_range;
    logic                  s1_adv;
    logic                  s1_fire;
    logic                  s1_proc_fire;
    logic                  s2_adv;
    logic                  out_load;
    logic                  mem_we;

    logic [TW-1:0]         base_eff;
    logic [TW-1:0]         last_val;
    logic                  has_hist;
    logic [TW-1:0]         rel_plain;
    logic signed [TW-1:0]  diff;
    logic                  disc;
    logic                  gap_hit;
    logic                  repair;
    logic                  rebase;
    logic [TW-1:0]         rel_fixed;
    logic [TW-1:0]         rel_val;
    logic [TW-1:0]         rebase_val;

    // Handshakes and pipeline advance.
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign corrected_us = corrected_reg;
    assign out_load     = s2_valid_reg && (!out_valid_reg || !out_stall);
    assign s2_adv       = !s2_valid_reg || out_load;
    assign s1_adv       = !s1_valid_reg || (s1_op_reg == mtmc_pkg::OP_CLEAR) || s2_adv;
    assign s1_fire      = s1_valid_reg && s1_adv;
    assign s1_proc_fire = s1_fire && (s1_op_reg == mtmc_pkg::OP_PROCESS);
    assign in_stall     = !s1_adv;
    assign in_accept    = in_valid && !in_stall;

    // Stream number to memory address.
    assign sn_ext   = IW'(stream_number);
    assign in_addr  = sn_ext[AW-1:0];
    assign in_range = {5'd0, stream_number} < NS8;

    // Correction of one item against its stream's history.
    always_comb
    begin
        base_eff   = base_known_reg ? base_reg : s1_ts_reg;
        last_val   = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ?
                     fwd_data_reg : rd_data_reg;
        has_hist   = s1_inrange_reg && known_reg[s1_addr_reg];
        rel_plain  = s1_ts_reg - base_eff;
        diff       = $signed(s1_ts_reg - base_eff - last_val);
        disc       = s1_eq_reg ? diff[TW-1] : (diff[TW-1] || (diff == '0));
        gap_hit    = diff >= $signed({{(TW - mtmc_pkg::DUR_W){1'b0}}, max_frame_reg});
        rebase     = disc || gap_hit || s1_force_reg;
        repair     = has_hist && (s1_primary_reg ? rebase : disc);
        rel_fixed  = last_val + {{(TW - mtmc_pkg::DUR_W){1'b0}}, dflt_frame_reg};
        rebase_val = s1_ts_reg - rel_fixed;
        rel_val    = repair ? rel_fixed : rel_plain;
        mem_we     = s1_proc_fire && s1_inrange_reg;
    end

    // Next values of the timing state.
    always_comb
    begin
        base_next       = base_reg;
        base_known_next = base_known_reg;
        known_next      = known_reg;
        if (s1_fire && (s1_op_reg == mtmc_pkg::OP_CLEAR))
        begin
            base_known_next = 1'b0;
            known_next      = '0;
        end
        else if (s1_proc_fire)
        begin
            base_known_next = 1'b1;
            base_next       = (repair && s1_primary_reg) ? rebase_val : base_eff;
            if (s1_inrange_reg)
            begin
                known_next[s1_addr_reg] = 1'b1;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg     <= mtmc_pkg::OFFSET_RST;
            max_frame_reg  <= mtmc_pkg::MAX_FRAME_RST;
            dflt_frame_reg <= mtmc_pkg::DFLT_FRAME_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (mtmc_pkg::cfg_idx_t'(cfg_index))
                mtmc_pkg::CFG_OFFSET:     offset_reg     <= cfg_data;
                mtmc_pkg::CFG_MAX_FRAME:  max_frame_reg  <= cfg_data[mtmc_pkg::DUR_W-1:0];
                mtmc_pkg::CFG_DFLT_FRAME: dflt_frame_reg <= cfg_data[mtmc_pkg::DUR_W-1:0];
                default:                  ;
            endcase
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            base_known_reg <= 1'b0;
            known_reg      <= '0;
            fwd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg <= in_accept;
            end
            if (s2_adv)
            begin
                s2_valid_reg <= s1_proc_fire;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            base_known_reg <= base_known_next;
            known_reg      <= known_next;
            if (mem_we)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg      <= mtmc_pkg::op_t'(opcode);
            s1_ts_reg      <= timestamp_us;
            s1_addr_reg    <= in_addr;
            s1_inrange_reg <= in_range;
            s1_primary_reg <= (stream_number == '0);
            s1_eq_reg      <= equal_allowed;
            s1_force_reg   <= force_discontinuity;
        end
        if (s1_proc_fire)
        begin
            rel_reg  <= rel_val;
            base_reg <= base_next;
        end
        if (out_load)
        begin
            corrected_reg <= rel_reg + offset_reg;
        end
        if (mem_we)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= rel_val;
        end
    end

    // Last-stamp memory: one read port at accept, one write port in stage 1.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            rd_data_reg <= stamp_mem[in_addr];
        end
        if (mem_we)
        begin
            stamp_mem[s1_addr_reg] <= rel_val;
        end
    end

`ifndef SYNTH
    // A clear item leaves no base time and no stream history behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && (s1_op_reg == mtmc_pkg::OP_CLEAR)) |=>
            (!base_known_reg && (known_reg == '0)))
        else $error("clear item did not drop timing state");

    // A process item always leaves a known base time.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_proc_fire |=> base_known_reg)
        else $error("base time not known after process item");

    // A stored stamp marks its stream as seen and is the forwarded entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> (known_reg[$past(s1_addr_reg)] && fwd_valid_reg
                    && (fwd_addr_reg == $past(s1_addr_reg))))
        else $error("stream write not recorded");

    // The input is held off only while stage 1 holds an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with empty stage 1");

    // A stage 2 item that cannot move keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s2_adv) |=> (s2_valid_reg && $stable(rel_reg)))
        else $error("stage 2 item lost while blocked");
`endif

endmodule
